// File: src/ess_pkg.sv
// Shared types, suffix and pattern tables, and a vowel helper for the suffix stripper.
// Used by every module in src; depends on nothing.
package ess_pkg;

    localparam int TAIL_N  = 11;  // bytes kept from the end of the word
    localparam int SFX_W   = 6;   // longest suffix in bytes
    localparam int PAT_W   = 7;   // longest add-e pattern in bytes
    localparam int WIN_N   = 7;   // stem bytes handed to the pattern stage
    localparam int SFX_N   = 27;
    localparam int PAT_N   = 30;
    localparam int KEEP_W  = 6;
    localparam int MIN_STEM = 3;

    // appended-letter codes
    localparam logic [1:0] APP_NONE = 2'd0;
    localparam logic [1:0] APP_Y    = 2'd1;
    localparam logic [1:0] APP_E    = 2'd2;

    // wildcard letters in the pattern table, and letters the undouble rule checks
    localparam logic [7:0] CH_CONS = "C";
    localparam logic [7:0] CH_VOW  = "V";
    localparam logic [7:0] CH_S    = "s";
    localparam logic [7:0] CH_L    = "l";

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [KEEP_W-1:0] keep_length;
        logic [1:0]        append_code;
        logic              too_long;
    } t_out_item;

    // one window position: byte, inside-the-word flag, vowel flag
    typedef struct packed {
        logic [7:0] chr;
        logic       vld;
        logic       vow;
    } t_tap;

    // control handed from the suffix stage to the final stage
    typedef struct packed {
        logic       ovf;   // word too long
        logic       fin;   // keep/app already final
        logic [1:0] app;
    } t_s2_ctl;

    // suffix entry; text right-justified, so byte j from the end is txt[8*j +: 8]
    typedef struct packed {
        logic [8*SFX_W-1:0] txt;
        logic [2:0]         old_len;
        logic [2:0]         new_len;
        logic               app_y;
        logic               eding;
        logic [1:0]         vdel;   // vowels removed minus vowels added
    } t_sfx;

    typedef struct packed {
        logic [8*PAT_W-1:0] txt;
        logic [2:0]         len;
        logic [1:0]         min_v;
        logic               add_e;
    } t_pat;

    localparam t_sfx SFX_TAB [SFX_N] = '{
        '{48'("is"),     3'd2, 3'd2, 1'b0, 1'b0, 2'd0},
        '{48'("ies"),    3'd3, 3'd1, 1'b1, 1'b0, 2'd1},
        '{48'("us"),     3'd2, 3'd2, 1'b0, 1'b0, 2'd0},
        '{48'("sses"),   3'd4, 3'd2, 1'b0, 1'b0, 2'd1},
        '{48'("xes"),    3'd3, 3'd1, 1'b0, 1'b0, 2'd1},
        '{48'("jones"),  3'd5, 3'd5, 1'b0, 1'b0, 2'd0},
        '{48'("ss"),     3'd2, 3'd2, 1'b0, 1'b0, 2'd0},
        '{48'("ings"),   3'd4, 3'd0, 1'b0, 1'b1, 2'd1},
        '{48'("namics"), 3'd6, 3'd6, 1'b0, 1'b0, 2'd0},
        '{48'("hysics"), 3'd6, 3'd6, 1'b0, 1'b0, 2'd0},
        '{48'("hes"),    3'd3, 3'd1, 1'b0, 1'b0, 2'd1},
        '{48'("autics"), 3'd6, 3'd6, 1'b0, 1'b0, 2'd0},
        '{48'("matics"), 3'd6, 3'd6, 1'b0, 1'b0, 2'd0},
        '{48'("stics"),  3'd5, 3'd5, 1'b0, 1'b0, 2'd0},
        '{48'("news"),   3'd4, 3'd4, 1'b0, 1'b0, 2'd0},
        '{48'("setts"),  3'd5, 3'd5, 1'b0, 1'b0, 2'd0},
        '{48'("denes"),  3'd5, 3'd5, 1'b0, 1'b0, 2'd0},
        '{48'("'s"),     3'd2, 3'd0, 1'b0, 1'b0, 2'd0},
        '{48'("s"),      3'd1, 3'd0, 1'b0, 1'b0, 2'd0},
        '{48'("speed"),  3'd5, 3'd5, 1'b0, 1'b1, 2'd0},
        '{48'("ied"),    3'd3, 3'd1, 1'b1, 1'b1, 2'd1},
        '{48'("ed"),     3'd2, 3'd0, 1'b0, 1'b1, 2'd1},
        '{48'("ssing"),  3'd5, 3'd2, 1'b0, 1'b1, 2'd1},
        '{48'("ing"),    3'd3, 3'd0, 1'b0, 1'b1, 2'd1},
        '{48'("ply"),    3'd3, 3'd3, 1'b0, 1'b0, 2'd0},
        '{48'("ily"),    3'd3, 3'd3, 1'b0, 1'b0, 2'd0},
        '{48'("ly"),     3'd2, 3'd0, 1'b0, 1'b0, 2'd1}
    };

    // 'C' is any non-vowel, 'V' any vowel, everything else literal
    localparam t_pat PAT_TAB [PAT_N] = '{
        '{56'("x"),       3'd1, 2'd0, 1'b0},
        '{56'("sponsor"), 3'd7, 2'd0, 1'b0},
        '{56'("monitor"), 3'd7, 2'd0, 1'b0},
        '{56'("og"),      3'd2, 2'd2, 1'b0},
        '{56'("Vg"),      3'd2, 2'd0, 1'b1},
        '{56'("ow"),      3'd2, 2'd0, 1'b0},
        '{56'("dit"),     3'd3, 2'd0, 1'b0},
        '{56'("er"),      3'd2, 2'd0, 1'b0},
        '{56'("el"),      3'd2, 2'd0, 1'b0},
        '{56'("ss"),      3'd2, 2'd0, 1'b0},
        '{56'("et"),      3'd2, 2'd0, 1'b0},
        '{56'("air"),     3'd3, 2'd0, 1'b0},
        '{56'("en"),      3'd2, 2'd2, 1'b0},
        '{56'("on"),      3'd2, 2'd2, 1'b0},
        '{56'("ong"),     3'd3, 2'd0, 1'b0},
        '{56'("CVC"),     3'd3, 2'd0, 1'b1},
        '{56'("VVv"),     3'd3, 2'd0, 1'b1},
        '{56'("Vlv"),     3'd3, 2'd0, 1'b1},
        '{56'("nc"),      3'd2, 2'd0, 1'b1},
        '{56'("pl"),      3'd2, 2'd0, 1'b1},
        '{56'("bl"),      3'd2, 2'd0, 1'b1},
        '{56'("rg"),      3'd2, 2'd0, 1'b1},
        '{56'("lg"),      3'd2, 2'd0, 1'b1},
        '{56'("dg"),      3'd2, 2'd0, 1'b1},
        '{56'("ng"),      3'd2, 2'd0, 1'b1},
        '{56'("iat"),     3'd3, 2'd0, 1'b1},
        '{56'("u"),       3'd1, 2'd0, 1'b1},
        '{56'("uir"),     3'd3, 2'd0, 1'b1},
        '{56'("Cs"),      3'd2, 2'd0, 1'b1},
        '{56'("us"),      3'd2, 2'd0, 1'b1}
    };

    // a e i o u y in either case
    function automatic logic is_vowel(input logic [7:0] c);
        logic v;
        unique case (c) inside
            "a", "e", "i", "o", "u", "y",
            "A", "E", "I", "O", "U", "Y": v = 1'b1;
            default:                      v = 1'b0;
        endcase
        return v;
    endfunction

endpackage

// File: src/ess_cell.sv
// One position of the tail window: holds a byte and its flags and hands them
// to the next position on every shift. Depends on ess_pkg.
module ess_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  logic          i_clear,
    input  ess_pkg::t_tap i_prev,
    output ess_pkg::t_tap o_tap,
    output ess_pkg::t_tap o_post
);
    import ess_pkg::*;

    t_tap r_tap;
    t_tap n_tap;

    // value after this cycle's shift, before the end-of-word clear
    assign o_post = i_shift ? i_prev : r_tap;
    assign o_tap  = r_tap;

    always_comb begin
        n_tap = o_post;
        if (i_clear) begin
            n_tap.vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else begin
            r_tap <= n_tap;
        end
    end

endmodule

// File: src/ess_suffix.sv
// Suffix stage: finds the first suffix entry that matches the window, checks
// the stem, and cuts out the stem window for the final stage. Depends on ess_pkg.
module ess_suffix #(
    parameter int LW = 6
) (
    input  ess_pkg::t_tap    i_tap [ess_pkg::TAIL_N],
    input  logic [LW-1:0]    i_len,
    input  logic [LW-1:0]    i_vc,
    input  logic             i_ovf,
    output ess_pkg::t_s2_ctl o_ctl,
    output ess_pkg::t_tap    o_win [ess_pkg::WIN_N],
    output logic [LW-1:0]    o_keep,
    output logic [LW-1:0]    o_nv
);
    import ess_pkg::*;

    logic [SFX_N-1:0] hit_v;
    t_sfx             sel;
    logic [LW-1:0]    stem_len;
    logic [LW-1:0]    cut_len;

    // one comparator per table entry; positions outside the word never match
    always_comb begin
        for (int i = 0; i < SFX_N; i++) begin
            hit_v[i] = 1'b1;
            for (int k = 0; k < SFX_W; k++) begin
                if (k < int'(SFX_TAB[i].old_len)) begin
                    if (!(i_tap[k].vld && i_tap[k].chr == SFX_TAB[i].txt[8*k +: 8])) begin
                        hit_v[i] = 1'b0;
                    end
                end
            end
        end
    end

    // first match wins
    always_comb begin
        sel = SFX_TAB[0];
        for (int i = SFX_N - 1; i >= 0; i--) begin
            if (hit_v[i]) begin
                sel = SFX_TAB[i];
            end
        end
    end

    assign cut_len  = LW'(sel.old_len);
    assign stem_len = i_len - cut_len + LW'(sel.new_len);
    assign o_nv     = i_vc - LW'(sel.vdel);

    // apply the entry, or keep the word when the stem is too short or vowel-free
    always_comb begin
        o_ctl.ovf = i_ovf;
        o_ctl.fin = 1'b1;
        o_ctl.app = APP_NONE;
        o_keep    = i_len;
        if (|hit_v) begin
            if (stem_len < LW'(MIN_STEM) || o_nv == '0) begin
                o_keep = i_len;
            end else if (sel.app_y) begin
                o_keep    = i_len - cut_len;
                o_ctl.app = APP_Y;
            end else begin
                o_keep    = stem_len;
                o_ctl.fin = !(sel.eding && sel.new_len == 3'd0);
            end
        end
    end

    // stem window: window position cut+j becomes stem position j
    always_comb begin
        logic [3:0] idx;
        for (int j = 0; j < WIN_N; j++) begin
            idx = 4'(j) + 4'(sel.old_len);
            if (idx < 4'(TAIL_N)) begin
                o_win[j] = i_tap[idx];
            end else begin
                o_win[j] = '0;
            end
        end
    end

endmodule

// File: src/ess_final.sv
// Final stage: undoubles a final consonant or runs the add-e pattern table on
// the stem window, then forms the result item. Depends on ess_pkg.
module ess_final #(
    parameter int LW = 6
) (
    input  ess_pkg::t_s2_ctl   i_ctl,
    input  ess_pkg::t_tap      i_win [ess_pkg::WIN_N],
    input  logic [LW-1:0]      i_keep,
    input  logic [LW-1:0]      i_nv,
    output ess_pkg::t_out_item o_item
);
    import ess_pkg::*;

    logic [PAT_N-1:0] pat_v;
    logic             pat_e;
    logic             undbl;

    // pattern comparators, one per entry
    always_comb begin
        logic [7:0] ch;
        for (int p = 0; p < PAT_N; p++) begin
            pat_v[p] = (LW'(PAT_TAB[p].min_v) <= i_nv);
            for (int k = 0; k < PAT_W; k++) begin
                ch = PAT_TAB[p].txt[8*k +: 8];
                if (k < int'(PAT_TAB[p].len)) begin
                    if (!i_win[k].vld) begin
                        pat_v[p] = 1'b0;
                    end else if (ch == CH_CONS) begin
                        if (i_win[k].vow) pat_v[p] = 1'b0;
                    end else if (ch == CH_VOW) begin
                        if (!i_win[k].vow) pat_v[p] = 1'b0;
                    end else if (i_win[k].chr != ch) begin
                        pat_v[p] = 1'b0;
                    end
                end
            end
        end
    end

    // first matching pattern decides the final 'e'
    always_comb begin
        pat_e = 1'b0;
        for (int p = PAT_N - 1; p >= 0; p--) begin
            if (pat_v[p]) begin
                pat_e = PAT_TAB[p].add_e;
            end
        end
    end

    // doubled final consonant, not 's'; 'l' only with more than one vowel
    assign undbl = !i_win[0].vow && i_win[0].chr != CH_S && i_win[0].chr == i_win[1].chr
                   && (i_win[0].chr != CH_L || i_nv > LW'(1));

    always_comb begin
        o_item.too_long    = 1'b0;
        o_item.keep_length = KEEP_W'(i_keep);
        o_item.append_code = i_ctl.app;
        if (i_ctl.ovf) begin
            o_item.too_long    = 1'b1;
            o_item.keep_length = '0;
            o_item.append_code = APP_NONE;
        end else if (!i_ctl.fin && i_win[0].vld && i_win[1].vld) begin
            if (undbl) begin
                o_item.keep_length = KEEP_W'(i_keep - LW'(1));
            end else if (pat_e) begin
                o_item.append_code = APP_E;
            end
        end
    end

endmodule

// File: src/english_suffix_stripper.sv
// English suffix stripper, top level. Takes one byte per cycle, back to back, while
// o_in_ready is high; a word's result item passes the snapshot register, the suffix
// stage register and the output register, in that order, one result per word.
// The window is a chain of eleven cells that shift every accepted byte while the word is under MAX_WORD.
// Synchronous active-low reset clears the window, counters and all valid flags.
module english_suffix_stripper #(
    parameter int MAX_WORD = 63
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ess_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ess_pkg::t_out_item o_out_item
);
    import ess_pkg::*;

    localparam int LW = $clog2(MAX_WORD + 1);

    // handshake
    logic acc, shift, clear;
    logic s1_rdy, s2_rdy, out_rdy;

    // tail chain
    t_tap head;
    t_tap tap  [TAIL_N];
    t_tap post [TAIL_N];

    // word counters
    logic [LW-1:0] r_len, n_len, r_vc, n_vc;
    logic          r_ovf, n_ovf;

    // snapshot stage
    logic          r_s1_v;
    t_tap          r_s1_tap [TAIL_N];
    logic [LW-1:0] r_s1_len, r_s1_vc;
    logic          r_s1_ovf;

    // suffix stage
    t_s2_ctl       s2_ctl;
    t_tap          s2_win [WIN_N];
    logic [LW-1:0] s2_keep, s2_nv;
    logic          r_s2_v;
    t_s2_ctl       r_s2_ctl;
    t_tap          r_s2_win [WIN_N];
    logic [LW-1:0] r_s2_keep, r_s2_nv;

    // output stage
    t_out_item     fin_item;
    logic          r_o_v;
    t_out_item     r_o_item;

    assign out_rdy    = !r_o_v || i_out_ready;
    assign s2_rdy     = !r_s2_v || out_rdy;
    assign s1_rdy     = !r_s1_v || s2_rdy;
    assign o_in_ready = s1_rdy;
    assign acc        = i_in_valid && s1_rdy;
    assign shift      = acc && (r_len != LW'(MAX_WORD));
    assign clear      = acc && i_in_item.last_char;

    assign head.chr = i_in_item.char_code;
    assign head.vld = 1'b1;
    assign head.vow = is_vowel(i_in_item.char_code);

    // chain of window cells, newest byte in cell 0
    for (genvar g = 0; g < TAIL_N; g++) begin : g_cell
        ess_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_clear (clear),
            .i_prev  ((g == 0) ? head : tap[(g == 0) ? 0 : g - 1]),
            .o_tap   (tap[g]),
            .o_post  (post[g])
        );
    end

    // length, vowel count and overflow flag
    assign n_len = shift ? r_len + LW'(1) : r_len;
    assign n_vc  = r_vc + LW'(shift && head.vow);
    assign n_ovf = r_ovf || (acc && !shift);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_len <= '0;
            r_vc  <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_len <= n_len;
            r_vc  <= n_vc;
            r_ovf <= n_ovf;
        end
    end

    // snapshot of the finished word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_rdy) begin
            r_s1_v <= clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (clear) begin
            r_s1_tap <= post;
            r_s1_len <= n_len;
            r_s1_vc  <= n_vc;
            r_s1_ovf <= n_ovf;
        end
    end

    ess_suffix #(.LW(LW)) u_suffix (
        .i_tap  (r_s1_tap),
        .i_len  (r_s1_len),
        .i_vc   (r_s1_vc),
        .i_ovf  (r_s1_ovf),
        .o_ctl  (s2_ctl),
        .o_win  (s2_win),
        .o_keep (s2_keep),
        .o_nv   (s2_nv)
    );

    // suffix stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_rdy) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_rdy && r_s1_v) begin
            r_s2_ctl  <= s2_ctl;
            r_s2_win  <= s2_win;
            r_s2_keep <= s2_keep;
            r_s2_nv   <= s2_nv;
        end
    end

    ess_final #(.LW(LW)) u_final (
        .i_ctl  (r_s2_ctl),
        .i_win  (r_s2_win),
        .i_keep (r_s2_keep),
        .i_nv   (r_s2_nv),
        .o_item (fin_item)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (out_rdy) begin
            r_o_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && r_s2_v) begin
            r_o_item <= fin_item;
        end
    end

    assign o_out_valid = r_o_v;
    assign o_out_item  = r_o_item;

endmodule
